FILE: rtl/assert_macros.svh
// Assertion macros for the nearest waypoint block.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define NWHP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check an implication on every clock edge outside reset
`define NWHP_IMPLY(label, cond, prop, msg) \
    `NWHP_ASSERT(label, (cond) |-> (prop), msg)

`endif

FILE: rtl/nwhp_pkg.sv
// Shared types and constants for the nearest waypoint heading penalty block.
// No dependencies.
`timescale 1ns / 1ps
package nwhp_pkg;
    localparam int MAX_WAYPOINTS_DEF = 4096;
    localparam int POS_W   = 24;
    localparam int HEAD_W  = 16;
    localparam int PEN_W   = 24;
    localparam int ANG_W   = 15;
    localparam int IDX_W   = 12;
    localparam int COST_W  = 26;
    localparam int DIFF_W  = POS_W + 1;
    localparam int SQ_W    = 2 * POS_W;
    localparam int SUM_W   = SQ_W + 1;
    localparam int ROOT_STEPS = (SUM_W + 1) / 2;
    localparam int STEP_W  = $clog2(ROOT_STEPS + 1);

    localparam logic [COST_W-1:0] COST_ONES = '1;
    localparam logic [PEN_W-1:0]  PENALTY_RESET = 24'd3840;
    localparam logic [ANG_W-1:0]  ANGLE_RESET = 15'd12868;
    localparam logic [HEAD_W:0]   PI_Q = 17'd25736;
    localparam logic [HEAD_W+1:0] TWO_PI_Q = 18'd51472;

    typedef enum logic [1:0] {
        KIND_BEGIN    = 2'd0,
        KIND_WAYPOINT = 2'd1,
        KIND_END      = 2'd2
    } t_kind;

    typedef enum logic {
        REG_PENALTY = 1'b0,
        REG_ANGLE   = 1'b1
    } t_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_SUM,
        S_ROOT,
        S_CMP,
        S_END
    } t_state;

    typedef struct packed {
        logic begin_q;
        logic take_wp;
        logic mark_ovf;
        logic sq_en;
        logic sqrt_init;
        logic sqrt_step;
        logic acc;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic full;
    } t_stat;
endpackage

FILE: rtl/nwhp_ctrl.sv
// Controller for the nearest waypoint block: sequences the square root and
// the output register. Depends on nwhp_pkg.
`timescale 1ns / 1ps
module nwhp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [1:0]      i_kind,
    output logic            o_stall,
    output logic            o_valid,
    input  logic            i_stall,
    input  nwhp_pkg::t_stat i_stat,
    output nwhp_pkg::t_cmd  o_cmd,
    output nwhp_pkg::t_state o_state
);
    nwhp_pkg::t_state r_state, n_state;
    logic [nwhp_pkg::STEP_W-1:0] r_step, n_step;
    logic r_valid, n_valid;
    logic acc_in;
    logic out_free;

    assign acc_in   = i_valid && (r_state == nwhp_pkg::S_IDLE);
    assign out_free = !r_valid || !i_stall;
    assign o_stall  = (r_state != nwhp_pkg::S_IDLE);
    assign o_valid  = r_valid;
    assign o_state  = r_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nwhp_pkg::S_IDLE: begin
                if (acc_in && i_kind == nwhp_pkg::KIND_WAYPOINT && !i_stat.full) begin
                    n_state = nwhp_pkg::S_SQ;
                end else if (acc_in && i_kind == nwhp_pkg::KIND_END && !out_free) begin
                    n_state = nwhp_pkg::S_END;
                end
            end
            nwhp_pkg::S_SQ:   n_state = nwhp_pkg::S_SUM;
            nwhp_pkg::S_SUM:  n_state = nwhp_pkg::S_ROOT;
            nwhp_pkg::S_ROOT: begin
                if (r_step == nwhp_pkg::STEP_W'(nwhp_pkg::ROOT_STEPS - 1)) begin
                    n_state = nwhp_pkg::S_CMP;
                end
            end
            nwhp_pkg::S_CMP:  n_state = nwhp_pkg::S_IDLE;
            nwhp_pkg::S_END: begin
                if (out_free) begin
                    n_state = nwhp_pkg::S_IDLE;
                end
            end
            default: n_state = nwhp_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        n_step = '0;
        unique case (r_state)
            nwhp_pkg::S_IDLE: begin
                if (acc_in) begin
                    unique case (i_kind)
                        nwhp_pkg::KIND_BEGIN:    o_cmd.begin_q = 1'b1;
                        nwhp_pkg::KIND_WAYPOINT: begin
                            o_cmd.take_wp  = !i_stat.full;
                            o_cmd.mark_ovf = i_stat.full;
                        end
                        nwhp_pkg::KIND_END:      o_cmd.load_out = out_free;
                        default: ;
                    endcase
                end
            end
            nwhp_pkg::S_SQ:   o_cmd.sq_en = 1'b1;
            nwhp_pkg::S_SUM:  o_cmd.sqrt_init = 1'b1;
            nwhp_pkg::S_ROOT: begin
                o_cmd.sqrt_step = 1'b1;
                n_step = r_step + 1'b1;
            end
            nwhp_pkg::S_CMP:  o_cmd.acc = 1'b1;
            nwhp_pkg::S_END:  o_cmd.load_out = out_free;
            default: ;
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (o_cmd.load_out) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nwhp_pkg::S_IDLE;
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end
endmodule

FILE: rtl/nwhp_dp.sv
// Datapath for the nearest waypoint block: pose, distance squares,
// bit-serial square root, argmin and result register. Depends on nwhp_pkg.
`timescale 1ns / 1ps
module nwhp_dp #(
    parameter int MAX_WAYPOINTS = nwhp_pkg::MAX_WAYPOINTS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  nwhp_pkg::t_cmd                       i_cmd,
    output nwhp_pkg::t_stat                      o_stat,
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_index,
    input  logic [nwhp_pkg::PEN_W-1:0]           i_cfg_data,
    input  logic signed [nwhp_pkg::POS_W-1:0]    i_pos_x,
    input  logic signed [nwhp_pkg::POS_W-1:0]    i_pos_y,
    input  logic signed [nwhp_pkg::HEAD_W-1:0]   i_heading,
    output logic                                 o_found,
    output logic [nwhp_pkg::IDX_W-1:0]           o_nearest_index,
    output logic [nwhp_pkg::COST_W-1:0]          o_best_cost,
    output logic                                 o_overflow
);
    localparam int CW = $clog2(MAX_WAYPOINTS + 1);
    localparam int SW = nwhp_pkg::SUM_W;

    logic [nwhp_pkg::PEN_W-1:0] r_penalty;
    logic [nwhp_pkg::ANG_W-1:0] r_angle;
    logic signed [nwhp_pkg::POS_W-1:0]  r_vx, r_vy;
    logic signed [nwhp_pkg::HEAD_W-1:0] r_vh;
    logic [CW-1:0] r_seen;
    logic [CW-1:0] r_best_idx;
    logic [nwhp_pkg::COST_W-1:0] r_best;
    logic r_ovf;

    logic signed [nwhp_pkg::DIFF_W-1:0] r_dx, r_dy;
    logic r_pen_on;
    logic [CW-1:0] r_idx;
    logic [nwhp_pkg::SQ_W-1:0] r_sqx, r_sqy;
    logic [SW-1:0] r_rem, r_root, r_bit;
    logic [SW-1:0] trial;

    logic signed [nwhp_pkg::HEAD_W:0]   hdiff;
    logic [nwhp_pkg::HEAD_W:0]          habs;
    logic signed [nwhp_pkg::HEAD_W+1:0] hwrap;
    logic [nwhp_pkg::HEAD_W:0]          hgap;
    logic [nwhp_pkg::COST_W-1:0] cost;

    logic r_found;
    logic [nwhp_pkg::IDX_W-1:0]  r_oidx;
    logic [nwhp_pkg::COST_W-1:0] r_ocost;
    logic r_oovf;

    assign o_stat.full = (r_seen >= CW'(MAX_WAYPOINTS));

    always_comb begin
        hdiff = (nwhp_pkg::HEAD_W+1)'(i_heading) - (nwhp_pkg::HEAD_W+1)'(r_vh);
        habs  = hdiff[nwhp_pkg::HEAD_W] ? nwhp_pkg::HEAD_W'(0) - hdiff : hdiff;
        hwrap = (nwhp_pkg::HEAD_W+2)'(habs);
        if (habs > nwhp_pkg::PI_Q) begin
            hwrap = (nwhp_pkg::HEAD_W+2)'(habs) - nwhp_pkg::TWO_PI_Q;
        end
        hgap = hwrap[nwhp_pkg::HEAD_W+1] ? (nwhp_pkg::HEAD_W+1)'(-hwrap)
                                         : (nwhp_pkg::HEAD_W+1)'(hwrap);
    end

    assign trial = r_root + r_bit;
    assign cost  = nwhp_pkg::COST_W'(r_root)
                 + (r_pen_on ? nwhp_pkg::COST_W'(r_penalty) : nwhp_pkg::COST_W'(0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_penalty  <= nwhp_pkg::PENALTY_RESET;
            r_angle    <= nwhp_pkg::ANGLE_RESET;
            r_vx       <= '0;
            r_vy       <= '0;
            r_vh       <= '0;
            r_seen     <= '0;
            r_best_idx <= '0;
            r_best     <= nwhp_pkg::COST_ONES;
            r_ovf      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    nwhp_pkg::REG_PENALTY: r_penalty <= i_cfg_data;
                    nwhp_pkg::REG_ANGLE:   r_angle <= i_cfg_data[nwhp_pkg::ANG_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.begin_q) begin
                r_vx       <= i_pos_x;
                r_vy       <= i_pos_y;
                r_vh       <= i_heading;
                r_seen     <= '0;
                r_best_idx <= '0;
                r_best     <= nwhp_pkg::COST_ONES;
                r_ovf      <= 1'b0;
            end
            if (i_cmd.mark_ovf) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.take_wp) begin
                r_seen <= r_seen + 1'b1;
            end
            if (i_cmd.acc && cost < r_best) begin
                r_best     <= cost;
                r_best_idx <= r_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_wp) begin
            r_dx     <= nwhp_pkg::DIFF_W'(i_pos_x) - nwhp_pkg::DIFF_W'(r_vx);
            r_dy     <= nwhp_pkg::DIFF_W'(i_pos_y) - nwhp_pkg::DIFF_W'(r_vy);
            r_pen_on <= hgap > (nwhp_pkg::HEAD_W+1)'(r_angle);
            r_idx    <= r_seen;
        end
        if (i_cmd.sq_en) begin
            r_sqx <= nwhp_pkg::SQ_W'(r_dx * r_dx);
            r_sqy <= nwhp_pkg::SQ_W'(r_dy * r_dy);
        end
        if (i_cmd.sqrt_init) begin
            r_rem  <= SW'(r_sqx) + SW'(r_sqy);
            r_root <= '0;
            r_bit  <= SW'(1) << (2 * (nwhp_pkg::ROOT_STEPS - 1));
        end else if (i_cmd.sqrt_step) begin
            if (r_rem >= trial) begin
                r_rem  <= r_rem - trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.load_out) begin
            r_found <= (r_seen != '0);
            r_oidx  <= (r_seen != '0) ? nwhp_pkg::IDX_W'(r_best_idx) : '0;
            r_ocost <= (r_seen != '0) ? r_best : '0;
            r_oovf  <= r_ovf;
        end
    end

    assign o_found         = r_found;
    assign o_nearest_index = r_oidx;
    assign o_best_cost     = r_ocost;
    assign o_overflow      = r_oovf;
endmodule

FILE: rtl/nearest_waypoint_heading_penalty.sv
// Top level of the nearest waypoint heading penalty block.
// Depends on nwhp_pkg, nwhp_ctrl, nwhp_dp and assert_macros.svh.
//
// Input channel (i_valid / o_stall) takes begin, waypoint and end transactions.
// A begin loads the vehicle pose and clears the search; a waypoint is measured
// against that pose; an end returns found, index, cost and overflow on the
// output channel (o_valid / i_stall). Unused kind 3 is dropped.
// Begin and waypoints past capacity never stall the input. A kept waypoint
// runs pose subtract, square, sum, a 25-step bit-serial square root (one
// result bit per cycle) and the compare into the running minimum, stalling
// the input until the compare is done.
// An end loads the output register in the cycle that accepts it if the register is free.
// While the receiver stalls, the result holds and the next transactions are
// still accepted; only a second end waits until the register frees.
// Configuration writes (i_cfg_valid / o_cfg_ready) are always ready.
// Synchronous active-low reset restores the default penalty and angle, zero
// pose and an empty search; the output channel comes up empty.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module nearest_waypoint_heading_penalty #(
    parameter int MAX_WAYPOINTS = nwhp_pkg::MAX_WAYPOINTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_kind,
    input  logic signed [nwhp_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [nwhp_pkg::POS_W-1:0]   i_pos_y,
    input  logic signed [nwhp_pkg::HEAD_W-1:0]  i_heading,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_found,
    output logic [nwhp_pkg::IDX_W-1:0]          o_nearest_index,
    output logic [nwhp_pkg::COST_W-1:0]         o_best_cost,
    output logic                                o_overflow,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_index,
    input  logic [nwhp_pkg::PEN_W-1:0]          i_cfg_data
);
    nwhp_pkg::t_cmd   cmd;
    nwhp_pkg::t_stat  stat;
    nwhp_pkg::t_state state;

    assign o_cfg_ready = 1'b1;

    nwhp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_state (state)
    );

    nwhp_dp #(
        .MAX_WAYPOINTS (MAX_WAYPOINTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_heading       (i_heading),
        .o_found         (o_found),
        .o_nearest_index (o_nearest_index),
        .o_best_cost     (o_best_cost),
        .o_overflow      (o_overflow)
    );

    `NWHP_IMPLY(a_wp_busy, i_valid && !o_stall && i_kind == nwhp_pkg::KIND_WAYPOINT && !stat.full, ##1 o_stall, "kept waypoint did not start the root sequence")
    `NWHP_IMPLY(a_empty_zero, o_valid && !o_found, o_best_cost == '0 && o_nearest_index == '0, "empty result carries nonzero cost or index")
    `NWHP_IMPLY(a_end_load, $rose(o_valid), $past(state == nwhp_pkg::S_END || (i_valid && !o_stall && i_kind == nwhp_pkg::KIND_END)), "result appeared without an end transaction")
endmodule

FILE: verif/nwhp_checker.sv
// Checker for the nearest waypoint heading penalty block: watches all three channels,
// predicts each end result and compares it field by field. Depends on nwhp_pkg.
`timescale 1ns / 1ps
module nwhp_checker #(
    parameter int MAX_WAYPOINTS = nwhp_pkg::MAX_WAYPOINTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic                               i_in_stall,
    input  logic [1:0]                         i_kind,
    input  logic signed [nwhp_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [nwhp_pkg::POS_W-1:0]  i_pos_y,
    input  logic signed [nwhp_pkg::HEAD_W-1:0] i_heading,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic                               i_found,
    input  logic [nwhp_pkg::IDX_W-1:0]         i_nearest_index,
    input  logic [nwhp_pkg::COST_W-1:0]        i_best_cost,
    input  logic                               i_overflow,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic                               i_cfg_index,
    input  logic [nwhp_pkg::PEN_W-1:0]         i_cfg_data,
    output int                                 o_errors,
    output int                                 o_pending
);
    import nwhp_pkg::*;

    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  index;
        logic [COST_W-1:0] cost;
        logic              overflow;
    } t_answer;

    t_answer answers_q[$];

    logic [PEN_W-1:0]         penalty;
    logic [ANG_W-1:0]         angle_lim;
    logic signed [POS_W-1:0]  car_x;
    logic signed [POS_W-1:0]  car_y;
    logic signed [HEAD_W-1:0] car_head;
    int unsigned              seen;
    logic [IDX_W-1:0]         best_idx;
    logic [COST_W-1:0]        best_cost;
    logic                     ovf;

    assign o_pending = answers_q.size();

    function automatic logic [31:0] isqrt_floor(logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r[31:0];
    endfunction

    function automatic int heading_gap(int a, int b);
        int d;
        d = a - b;
        if (d < 0) d = -d;
        while (d > int'(PI_Q)) d -= int'(TWO_PI_Q);
        if (d < 0) d = -d;
        return d;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        longint   dx;
        longint   dy;
        logic [31:0] cost;
        t_answer  a;
        t_answer  w;
        if (!i_rst_n) begin
            penalty   = PENALTY_RESET;
            angle_lim = ANGLE_RESET;
            car_x     = '0;
            car_y     = '0;
            car_head  = '0;
            seen      = 0;
            best_idx  = '0;
            best_cost = COST_ONES;
            ovf       = 1'b0;
            answers_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_PENALTY) penalty = i_cfg_data;
                else angle_lim = i_cfg_data[ANG_W-1:0];
            end
            if (i_out_valid && !i_out_stall) begin
                a = '{i_found, i_nearest_index, i_best_cost, i_overflow};
                if (answers_q.size() == 0) begin
                    report("unexpected result, found", a.found, 0);
                end else begin
                    w = answers_q.pop_front();
                    if (a.found !== w.found) report("found", a.found, w.found);
                    if (a.index !== w.index) report("nearest_index", a.index, w.index);
                    if (a.cost !== w.cost) report("best_cost", a.cost, w.cost);
                    if (a.overflow !== w.overflow) report("overflow", a.overflow, w.overflow);
                end
            end
            if (i_valid && !i_in_stall) begin
                case (i_kind)
                    KIND_BEGIN: begin
                        car_x     = i_pos_x;
                        car_y     = i_pos_y;
                        car_head  = i_heading;
                        seen      = 0;
                        best_idx  = '0;
                        best_cost = COST_ONES;
                        ovf       = 1'b0;
                    end
                    KIND_WAYPOINT: begin
                        if (seen >= MAX_WAYPOINTS) begin
                            ovf = 1'b1;
                        end else begin
                            dx = longint'(i_pos_x) - longint'(car_x);
                            dy = longint'(i_pos_y) - longint'(car_y);
                            cost = isqrt_floor(64'(dx * dx) + 64'(dy * dy));
                            if (heading_gap(int'(i_heading), int'(car_head)) > int'(angle_lim))
                                cost = cost + penalty;
                            if (cost < best_cost) begin
                                best_cost = cost[COST_W-1:0];
                                best_idx  = seen[IDX_W-1:0];
                            end
                            seen++;
                        end
                    end
                    KIND_END: begin
                        if (seen != 0) w = '{1'b1, best_idx, best_cost, ovf};
                        else w = '{1'b0, '0, '0, ovf};
                        answers_q.push_back(w);
                    end
                    default: ;
                endcase
            end
        end
    end
endmodule

FILE: verif/tb_nearest_waypoint_heading_penalty.sv
// Testbench top for the nearest waypoint heading penalty block; depends on it, nwhp_pkg and
// nwhp_checker. Runs directed queries, then random query streams with idling on both sides.
`timescale 1ns / 1ps
module tb_nearest_waypoint_heading_penalty;
    import nwhp_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 40;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic [1:0]               i_kind;
    logic signed [POS_W-1:0]  i_pos_x;
    logic signed [POS_W-1:0]  i_pos_y;
    logic signed [HEAD_W-1:0] i_heading;
    logic                     o_valid;
    logic                     i_stall;
    logic                     o_found;
    logic [IDX_W-1:0]         o_nearest_index;
    logic [COST_W-1:0]        o_best_cost;
    logic                     o_overflow;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic                     i_cfg_index;
    logic [PEN_W-1:0]         i_cfg_data;

    int errors;
    int pending;
    int sent;
    int idle_cycles;
    bit quiet;

    nearest_waypoint_heading_penalty dut (.*);

    nwhp_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_in_stall(o_stall), .i_kind(i_kind),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_heading(i_heading),
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_found(o_found),
        .i_nearest_index(o_nearest_index), .i_best_cost(o_best_cost),
        .i_overflow(o_overflow),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver stall bursts
    initial begin
        int left;
        bit hold;
        left = 0;
        hold = 0;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (left == 0) begin
                hold = $urandom_range(0, 2) == 0;
                left = $urandom_range(1, 17);
            end
            left--;
            i_stall <= hold && !quiet;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send(logic [1:0] kind, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                        logic [HEAD_W-1:0] h);
        i_valid   <= 1'b1;
        i_kind    <= kind;
        i_pos_x   <= x;
        i_pos_y   <= y;
        i_heading <= h;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent++;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg idx, logic [PEN_W-1:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [POS_W-1:0] pick_pos(logic [POS_W-1:0] center);
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            default: return center + POS_W'($urandom_range(0, 4000)) - POS_W'(2000);
        endcase
    endfunction

    function automatic logic [HEAD_W-1:0] pick_head();
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 16'sd25736 : -16'sd25736;
            default: return HEAD_W'($urandom_range(0, 51472)) - HEAD_W'(25736);
        endcase
    endfunction

    initial begin
        logic [POS_W-1:0] cx;
        logic [POS_W-1:0] cy;
        int n;
        sent = 0;
        quiet = 0;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_kind = KIND_BEGIN;
        i_pos_x = '0;
        i_pos_y = '0;
        i_heading = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_PENALTY;
        i_cfg_data = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty query, waypoint against reset pose, extremes, ties, unused kind
        send(KIND_END, 0, 0, 0);
        send(KIND_WAYPOINT, 24'h000300, 24'h000400, 16'sd20000);
        send(KIND_END, 0, 0, 0);
        send(KIND_BEGIN, 24'h800000, 24'h800000, -16'sd25736);
        send(KIND_WAYPOINT, 24'h7FFFFF, 24'h7FFFFF, 16'sd25736);
        send(KIND_WAYPOINT, 24'h800000, 24'h800000, -16'sd25736);
        send(KIND_WAYPOINT, 24'h800000, 24'h800000, 16'sd32767);
        send(KIND_WAYPOINT, 24'h800000, 24'h800000, -16'sd32768);
        send(KIND_WAYPOINT, 24'h800000, 24'h800000, 16'sd0);
        send(KIND_UNUSED, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
        send(KIND_END, 0, 0, 0);
        send(KIND_END, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
        send(KIND_BEGIN, 0, 0, 0);
        send(KIND_END, 0, 0, 0);
        write_reg(REG_PENALTY, 0);
        write_reg(REG_ANGLE, 0);
        send(KIND_BEGIN, 24'h000100, 24'hFFFF00, 16'sd100);
        send(KIND_WAYPOINT, 24'h000900, 24'hFFFF00, -16'sd100);
        send(KIND_WAYPOINT, 24'h000100, 24'h000700, 16'sd100);
        send(KIND_END, 0, 0, 0);
        write_reg(REG_PENALTY, 24'hFFFFFF);
        write_reg(REG_ANGLE, 24'd25736);
        send(KIND_BEGIN, 0, 0, 16'sd25000);
        send(KIND_WAYPOINT, 24'h7FFFFF, 24'h800000, -16'sd25000);
        send(KIND_WAYPOINT, 24'h100000, 0, 16'sd25000);
        send(KIND_END, 0, 0, 0);

        // capacity: fill past the limit, no idling to keep it short
        quiet = 1;
        write_reg(REG_PENALTY, PENALTY_RESET);
        write_reg(REG_ANGLE, ANGLE_RESET);
        send(KIND_BEGIN, 0, 0, 0);
        for (int k = 0; k < MAX_WAYPOINTS_DEF + 5; k++)
            send(KIND_WAYPOINT, 24'(5000 - k), 24'($urandom_range(0, 30)), pick_head());
        send(KIND_END, 0, 0, 0);
        send(KIND_END, 0, 0, 0);
        quiet = 0;
        sent = 0;

        while (sent < 1550) begin
            if ($urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 3))
                    0: write_reg(REG_PENALTY, $urandom);
                    1: write_reg(REG_PENALTY, $urandom_range(0, 10000));
                    2: write_reg(REG_ANGLE, $urandom_range(0, 25736));
                    default: write_reg(REG_ANGLE, $urandom_range(0, 1) ? 25736 : 0);
                endcase
            end
            if (sent > 1350) quiet = 1;
            repeat ($urandom_range(1, 4)) begin
                cx = $urandom;
                cy = $urandom;
                if ($urandom_range(0, 9) != 0) send(KIND_BEGIN, cx, cy, pick_head());
                n = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 12);
                repeat (n) begin
                    if ($urandom_range(0, 19) == 0)
                        send(KIND_UNUSED, $urandom, $urandom, $urandom);
                    send(KIND_WAYPOINT, pick_pos(cx), pick_pos(cy), pick_head());
                end
                send(KIND_END, 0, 0, 0);
                if ($urandom_range(0, 7) == 0) send(KIND_END, $urandom, $urandom, $urandom);
            end
        end

        drain();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+rtl
rtl/nwhp_pkg.sv
rtl/nwhp_ctrl.sv
rtl/nwhp_dp.sv
rtl/nearest_waypoint_heading_penalty.sv
verif/nwhp_checker.sv
verif/tb_nearest_waypoint_heading_penalty.sv
